// File: src/amt_pkg.sv
`timescale 1ns / 1ps
// amt_pkg: sizes, status and command codes, cell token and entry types
// for the address range map table. No dependencies.
package amt_pkg;

  localparam int MAP_ENTRIES   = 32;
  localparam int NUM_MAPS      = 4;

  localparam int CMD_W         = 1;
  localparam int SEL_W         = 2;
  localparam int ADDR_W        = 32;
  localparam int MOD_W         = 8;
  localparam int STATUS_W      = 3;
  localparam int ENTRY_COUNT_W = 6;

  localparam int COUNT_W   = $clog2(MAP_ENTRIES + 1);
  localparam int MAP_IDX_W = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;
  localparam int CNT_EXT_W = (COUNT_W > ENTRY_COUNT_W) ? COUNT_W : ENTRY_COUNT_W;

  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERLAP   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;

  // one stored range
  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
    logic [MOD_W-1:0]  owner;
  } entry_t;

  // command word as it walks down the row of cells
  typedef struct packed {
    logic                 valid;
    logic [CMD_W-1:0]     cmd;
    logic [MAP_IDX_W-1:0] sel;
    logic [ADDR_W-1:0]    range_start;
    logic [ADDR_W-1:0]    range_end;
    logic [MOD_W-1:0]     module_id;
    logic [COUNT_W-1:0]   cnt;   // entries in the table at launch
    logic [COUNT_W-1:0]   idx;   // slot of the cell the word is entering
    logic                 hit;   // overlap (insert) or match (remove) seen
    logic                 dup;   // the overlap seen was an exact duplicate
  } tok_t;

  // table selector folded onto NUM_MAPS: a few narrow subtract steps
  function automatic logic [MAP_IDX_W-1:0] map_reduce(input logic [SEL_W-1:0] sel);
    logic [SEL_W:0] r;
    r = {1'b0, sel};
    for (int i = 0; i < 4; i++) begin
      if (int'(r) >= NUM_MAPS) begin
        r = r - (SEL_W+1)'(NUM_MAPS);
      end
    end
    return MAP_IDX_W'(r);
  endfunction

endpackage

// File: src/amt_req_if.sv
`timescale 1ns / 1ps
// amt_req_if: command channel of the range map table (valid/ready + word).
// Depends on amt_pkg.
interface amt_req_if;
  logic                           valid;
  logic                           ready;
  logic [amt_pkg::CMD_W-1:0]      cmd;
  logic [amt_pkg::SEL_W-1:0]      map_select;
  logic [amt_pkg::ADDR_W-1:0]     range_start;
  logic [amt_pkg::ADDR_W-1:0]     range_end;
  logic [amt_pkg::MOD_W-1:0]      module_id;

  modport source (output valid, cmd, map_select, range_start, range_end, module_id,
                  input ready);
  modport sink   (input valid, cmd, map_select, range_start, range_end, module_id,
                  output ready);
endinterface

// File: src/amt_rsp_if.sv
`timescale 1ns / 1ps
// amt_rsp_if: status channel of the range map table (valid/ready + word).
// Depends on amt_pkg.
interface amt_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [amt_pkg::STATUS_W-1:0]         status;
  logic [amt_pkg::ENTRY_COUNT_W-1:0]    entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink   (input valid, status, entry_count, output ready);
endinterface

// File: src/amt_cell.sv
`timescale 1ns / 1ps
// amt_cell: one slot of every table; checks the passing command word and
// hands it on. Depends on amt_pkg.
module amt_cell (
  input  logic            clk,
  input  logic            rst,
  input  amt_pkg::tok_t   tok_in,
  input  amt_pkg::entry_t nxt_entry,
  output amt_pkg::tok_t   tok_out,
  output amt_pkg::entry_t up_entry
);

  amt_pkg::entry_t ent [amt_pkg::NUM_MAPS];
  amt_pkg::entry_t cur;
  amt_pkg::tok_t   tok;
  amt_pkg::tok_t   tok_next;
  logic            active;
  logic            ovl;
  logic            exact;

  assign cur      = ent[tok_in.sel];
  assign up_entry = cur;
  assign tok_out  = tok;

  always_comb begin
    active = tok_in.valid && (tok_in.idx < tok_in.cnt);
    ovl    = (tok_in.range_start < cur.end_addr) && (tok_in.range_end > cur.start_addr);
    exact  = (tok_in.range_start == cur.start_addr) && (tok_in.range_end == cur.end_addr) &&
             (tok_in.module_id == cur.owner);
    tok_next     = tok_in;
    tok_next.idx = tok_in.idx + 1'b1;
    if (active && !tok_in.hit) begin
      if (tok_in.cmd == amt_pkg::CMD_INSERT) begin
        tok_next.hit = ovl;
        tok_next.dup = ovl && exact;
      end else begin
        tok_next.hit = exact;
        tok_next.dup = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok <= tok_next;
    end
  end

  // insert drops the range into the first free slot; kept only if the
  // count moves. Remove pulls every later slot down by one.
  always_ff @(posedge clk) begin
    if (tok_in.valid && tok_in.cmd == amt_pkg::CMD_INSERT && tok_in.idx == tok_in.cnt) begin
      ent[tok_in.sel].start_addr <= tok_in.range_start;
      ent[tok_in.sel].end_addr   <= tok_in.range_end;
      ent[tok_in.sel].owner      <= tok_in.module_id;
    end else if (tok.valid && tok.cmd == amt_pkg::CMD_REMOVE && tok.hit) begin
      ent[tok.sel] <= nxt_entry;
    end
  end

endmodule

// File: src/address_range_map_table.sv
`timescale 1ns / 1ps
// address_range_map_table: top level; row of amt_cell slots, per-table
// counts and the result buffer. Depends on amt_pkg, amt_req_if, amt_rsp_if.
//
//  port  dir   word fields                                          handshake
//  ----  ----  ---------------------------------------------------  ---------
//  req   in    cmd, map_select, range_start, range_end, module_id   valid/ready
//  rsp   out   status, entry_count                                  valid/ready
//
// One word in flight: it walks one cell per cycle down MAP_ENTRIES cells,
// and its result is then registered in the output register; req opens
// again in that same cycle unless the skid slot is full, so a new word
// is taken only once the last one has left the row of cells.
// rst (synchronous) clears the counts, the word valids and the buffer and
// holds req off; stored ranges are left as they are and never read until written.
// A stalled result sits in the output register and the next word is still
// taken; its result drops into a skid slot. req is held off while a word is
// in the row or while the skid slot is full.
module address_range_map_table (
  input  logic  clk,
  input  logic  rst,
  amt_req_if.sink   req,
  amt_rsp_if.source rsp
);

  localparam int N = amt_pkg::MAP_ENTRIES;

  logic                           busy;
  logic [amt_pkg::COUNT_W-1:0]    count [amt_pkg::NUM_MAPS];
  amt_pkg::tok_t                  launch_tok;
  amt_pkg::tok_t                  chain [N];
  amt_pkg::entry_t                up    [N];
  amt_pkg::tok_t                  tok_end;
  logic                           accept;

  logic [amt_pkg::STATUS_W-1:0]   res_status;
  logic [amt_pkg::COUNT_W-1:0]    res_cnt;
  logic [amt_pkg::CNT_EXT_W-1:0]  res_cnt_ext;
  logic [amt_pkg::ENTRY_COUNT_W-1:0] res_count;

  logic                              out_vld;
  logic [amt_pkg::STATUS_W-1:0]      out_status;
  logic [amt_pkg::ENTRY_COUNT_W-1:0] out_count;
  logic                              skid_vld;
  logic [amt_pkg::STATUS_W-1:0]      skid_status;
  logic [amt_pkg::ENTRY_COUNT_W-1:0] skid_count;
  logic                              take;

  assign req.ready = !rst && !busy && !skid_vld;
  assign accept    = req.valid && req.ready;

  // launch word: the table count rides along so the cells need no lookup
  always_comb begin
    launch_tok.valid       = accept;
    launch_tok.cmd         = req.cmd;
    launch_tok.sel         = amt_pkg::map_reduce(req.map_select);
    launch_tok.range_start = req.range_start;
    launch_tok.range_end   = req.range_end;
    launch_tok.module_id   = req.module_id;
    launch_tok.cnt         = count[launch_tok.sel];
    launch_tok.idx         = '0;
    launch_tok.hit         = 1'b0;
    launch_tok.dup         = 1'b0;
  end

  // cell row: cell k holds slot k of every table
  for (genvar k = 0; k < N; k++) begin : g_cell
    amt_pkg::tok_t   cell_in;
    amt_pkg::entry_t cell_nxt;
    if (k == 0) begin : g_first
      assign cell_in = launch_tok;
    end else begin : g_mid
      assign cell_in = chain[k-1];
    end
    if (k == N - 1) begin : g_last
      assign cell_nxt = '0;
    end else begin : g_inner
      assign cell_nxt = up[k+1];
    end
    amt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (cell_in),
      .nxt_entry (cell_nxt),
      .tok_out   (chain[k]),
      .up_entry  (up[k])
    );
  end

  assign tok_end = chain[N-1];

  // verdict once the word leaves the last cell; for insert the check order is
  // empty range, then overlap/duplicate, then full; remove gives removed or not-found
  always_comb begin
    res_cnt = tok_end.cnt;
    if (tok_end.cmd == amt_pkg::CMD_INSERT) begin
      if (tok_end.range_end <= tok_end.range_start) begin
        res_status = amt_pkg::ST_EMPTY;
      end else if (tok_end.hit) begin
        res_status = tok_end.dup ? amt_pkg::ST_DUPLICATE : amt_pkg::ST_OVERLAP;
      end else if (tok_end.cnt >= amt_pkg::COUNT_W'(N)) begin
        res_status = amt_pkg::ST_FULL;
      end else begin
        res_status = amt_pkg::ST_INSERTED;
        res_cnt    = tok_end.cnt + 1'b1;
      end
    end else begin
      if (tok_end.hit) begin
        res_status = amt_pkg::ST_REMOVED;
        res_cnt    = tok_end.cnt - 1'b1;
      end else begin
        res_status = amt_pkg::ST_NOT_FOUND;
      end
    end
    res_cnt_ext = amt_pkg::CNT_EXT_W'(res_cnt);
    res_count   = res_cnt_ext[amt_pkg::ENTRY_COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      for (int m = 0; m < amt_pkg::NUM_MAPS; m++) begin
        count[m] <= '0;
      end
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (tok_end.valid) begin
        busy <= 1'b0;
      end
      if (tok_end.valid) begin
        count[tok_end.sel] <= res_cnt;
      end
    end
  end

  // result buffer: output register plus one skid slot
  assign take            = out_vld && rsp.ready;
  assign rsp.valid       = out_vld;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (tok_end.valid) begin
        if (!out_vld || take) begin
          out_vld    <= 1'b1;
          out_status <= res_status;
          out_count  <= res_count;
        end else begin
          skid_vld    <= 1'b1;
          skid_status <= res_status;
          skid_count  <= res_count;
        end
      end else if (take) begin
        if (skid_vld) begin
          out_status <= skid_status;
          out_count  <= skid_count;
          skid_vld   <= 1'b0;
        end else begin
          out_vld <= 1'b0;
        end
      end
    end
  end

endmodule

// File: src/amt_checker.sv
`timescale 1ns / 1ps
// amt_checker: port-level checks for address_range_map_table, bound to the
// top level. Depends on amt_pkg.
module amt_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 req_valid,
  input logic                                 req_ready,
  input logic                                 rsp_valid,
  input logic                                 rsp_ready,
  input logic [amt_pkg::STATUS_W-1:0]         status,
  input logic [amt_pkg::ENTRY_COUNT_W-1:0]    entry_count
);

  // one word at a time: taking a word closes the door
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("req accepted twice in a row");

  // a result cannot appear the cycle after its word went in
  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !$rose(rsp_valid))
    else $error("result appeared too early");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(entry_count)))
    else $error("stalled result word changed");

  // no code beyond not-found is ever produced
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status <= amt_pkg::ST_NOT_FOUND))
    else $error("undefined status code");

endmodule

bind address_range_map_table amt_checker u_amt_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .entry_count (rsp.entry_count)
);
